// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsd check failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsd check failed");

`endif

// File: sv/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

	// 7-bit length codes that select an extended length field
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// byte count of the 16-bit extended length and index of the last mask byte
	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] MASK_LAST_IDX = 3'd3;

	// per-request decision handed from the parser to the output stage
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [7:0] key;
		logic       masked;
		logic [3:0] opcode;
		logic       fin;
		logic       empty;
		logic       last;
	} wsd_res_t;

endpackage
`default_nettype wire

// File: sv/wsd_raw_if.sv
`default_nettype none
interface wsd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: sv/wsd_frame_if.sv
`default_nettype none
interface wsd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       final_fragment;
	logic       was_masked;
	logic       empty_frame;
	logic       last;

	modport source (
		output valid, output payload_byte, output frame_opcode, output final_fragment,
		output was_masked, output empty_frame, output last, input ready
	);
	modport sink (
		input valid, input payload_byte, input frame_opcode, input final_fragment,
		input was_masked, input empty_frame, input last, output ready
	);
endinterface
`default_nettype wire

// File: sv/wsd_parser.sv
`default_nettype none
module wsd_parser import wsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] in_byte,
	output wsd_res_t        res
);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [2:0]      cnt_q, cnt_d;
	logic            fin_q, fin_d;
	logic [3:0]      op_q, op_d;
	logic            mask_q, mask_d;
	logic [63:0]     len_q, len_d;
	logic [3:0][7:0] key_q, key_d;
	logic [1:0]      pos_q, pos_d;

	always_comb begin
		logic [2:0] cnt_inc;
		logic [6:0] len7;
		logic       len_done;
		logic       hdr_done;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		fin_d    = fin_q;
		op_d     = op_q;
		mask_d   = mask_q;
		len_d    = len_q;
		key_d    = key_q;
		pos_d    = pos_q;
		res      = '0;
		cnt_inc  = cnt_q + 3'd1;
		len7     = in_byte[6:0];
		len_done = 1'b0;
		hdr_done = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_d = in_byte[7];
				cnt_d  = 3'd0;
				if (len7 == LEN_CODE_EXT16) begin
					len_d   = '0;
					phase_d = PH_EXT16;
				end else if (len7 == LEN_CODE_EXT64) begin
					len_d   = '0;
					phase_d = PH_EXT64;
				end else begin
					len_d    = {57'd0, len7};
					len_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				// big-endian: shift in low byte
				len_d = {len_q[55:0], in_byte};
				cnt_d = cnt_inc;
				if ((phase_q == PH_EXT16 && cnt_inc == EXT16_BYTES) ||
				    (phase_q == PH_EXT64 && cnt_inc == 3'd0)) begin
					len_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_d[cnt_q[1:0]] = in_byte;
				cnt_d = cnt_inc;
				if (cnt_q == MASK_LAST_IDX) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				len_d = len_q - 64'd1;
				if (mask_q) begin
					pos_d = pos_q + 2'd1;
				end
				res.valid = 1'b1;
				res.data  = in_byte;
				res.key   = key_q[pos_q];
				res.last  = (len_q == 64'd1);
				if (res.last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				// first header byte; unused codes land here as well
				fin_d   = in_byte[7];
				op_d    = in_byte[3:0];
				cnt_d   = 3'd0;
				phase_d = PH_HDR1;
			end
		endcase
		if (len_done) begin
			cnt_d = 3'd0;
			if (mask_d) begin
				phase_d = PH_MASK;
			end else begin
				hdr_done = 1'b1;
			end
		end
		if (hdr_done) begin
			pos_d = 2'd0;
			cnt_d = 3'd0;
			if (len_d == 64'd0) begin
				res.valid = 1'b1;
				res.empty = 1'b1;
				res.last  = 1'b1;
				phase_d   = PH_HDR0;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end
		res.opcode = op_d;
		res.fin    = fin_d;
		res.masked = mask_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			key_q   <= '0;
			pos_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			len_q   <= len_d;
			key_q   <= key_d;
			pos_q   <= pos_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/wsd_out_stage.sv
`default_nettype none
module wsd_out_stage import wsd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire wsd_res_t res,
	wsd_frame_if.source   frame
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [3:0] op_q;
	logic       fin_q;
	logic       masked_q;
	logic       empty_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	// unmask on the way into the result register
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			byte_q   <= res.masked ? (res.data ^ res.key) : res.data;
			op_q     <= res.opcode;
			fin_q    <= res.fin;
			masked_q <= res.masked;
			empty_q  <= res.empty;
			last_q   <= res.last;
		end
	end

	assign frame.valid          = valid_q;
	assign frame.payload_byte   = byte_q;
	assign frame.frame_opcode   = op_q;
	assign frame.final_fragment = fin_q;
	assign frame.was_masked     = masked_q;
	assign frame.empty_frame    = empty_q;
	assign frame.last           = last_q;

endmodule
`default_nettype wire

// File: sv/websocket_frame_deframer_unmask_top.sv
// channel  | modport | payload                                         | per request
// raw      | sink    | in_byte                                         | one link byte
// frame    | source  | payload_byte frame_opcode final_fragment        | zero or one result
//          |         | was_masked empty_frame last                     |
//
// one byte per cycle while frame accepts; every byte is decided in the cycle it is taken
// a result shows on frame in the cycle after the byte that caused it
// header bytes produce nothing; a zero-length frame gives one empty result
// raw.ready drops only while a result sits in the output register unaccepted
// arst_n clears the parser to expect the first header byte
`default_nettype none
`include "assert_macros.svh"
module websocket_frame_deframer_unmask_top import wsd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wsd_raw_if.sink     raw,
	wsd_frame_if.source frame
);

	wsd_res_t res;
	logic     fire;

	// output register free now or emptying this cycle
	assign raw.ready = !frame.valid || frame.ready;
	assign fire      = raw.valid && raw.ready;

	// header parse, length count and key select
	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (raw.in_byte),
		.res     (res)
	);

	// xor and result register
	wsd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res    (res),
		.frame  (frame)
	);

	// an accepted byte that yields a result must show it next cycle
	`WSD_ASSERT_NEXT(a_result_appears, fire && res.valid, frame.valid)
	// empty frames carry a zero byte and close the frame
	`WSD_ASSERT_SAME(a_empty_shape, frame.valid && frame.empty_frame,
		frame.last && frame.payload_byte == 8'd0)
	// a result that is not last is never an empty frame
	`WSD_ASSERT_SAME(a_mid_not_empty, frame.valid && !frame.last, !frame.empty_frame)
	// a held result blocks the input side
	`WSD_ASSERT_SAME(a_stall_blocks, frame.valid && !frame.ready, !raw.ready)

endmodule
`default_nettype wire

// File: test/websocket_frame_deframer_unmask_checker.sv
`timescale 1ns / 100ps
module websocket_frame_deframer_unmask_checker import wsd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wsd_raw_if          raw,
	wsd_frame_if        frame,
	input  wire logic   end_of_run,
	output logic        at_frame_start,
	output int unsigned pending,
	output int unsigned fail_count
);

	typedef enum logic [2:0] {
		AWAIT_FIRST, AWAIT_LEN, EXT_SHORT, EXT_LONG, KEY_BYTES, PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       masked;
		logic       empty;
		logic       last;
	} frame_result_t;

	parse_phase_t  phase_q;
	logic [2:0]    hdr_cnt;
	logic          fin_q;
	logic [3:0]    op_q;
	logic          masked_q;
	logic [63:0]   remain_q;
	logic [7:0]    key_q [0:3];
	logic [1:0]    key_pos;
	frame_result_t expected_results[$];
	frame_result_t want;
	logic          end_checked;

	assign at_frame_start = (phase_q == AWAIT_FIRST);

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (fail_count < 50) begin
			$display("[%0t] mismatch %s: got 0x%0h, wanted 0x%0h", $time, what, got, exp_val);
		end
		fail_count++;
	endtask

	function automatic void push_result(input logic [7:0] d, input logic e, input logic l);
		expected_results.push_back('{data: d, opcode: op_q, fin: fin_q, masked: masked_q,
			empty: e, last: l});
	endfunction

	// header complete: empty result or on to payload
	function automatic void finish_header();
		key_pos = 2'd0;
		hdr_cnt = 3'd0;
		if (remain_q == 64'd0) begin
			push_result(8'd0, 1'b1, 1'b1);
			phase_q = AWAIT_FIRST;
		end else begin
			phase_q = PAYLOAD;
		end
	endfunction

	function automatic void finish_length();
		hdr_cnt = 3'd0;
		if (masked_q) begin
			phase_q = KEY_BYTES;
		end else begin
			finish_header();
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [7:0] d;
		case (phase_q)
			AWAIT_LEN: begin
				masked_q = b[7];
				hdr_cnt = 3'd0;
				if (b[6:0] == LEN_CODE_EXT16) begin
					remain_q = 64'd0;
					phase_q = EXT_SHORT;
				end else if (b[6:0] == LEN_CODE_EXT64) begin
					remain_q = 64'd0;
					phase_q = EXT_LONG;
				end else begin
					remain_q = {57'd0, b[6:0]};
					finish_length();
				end
			end
			EXT_SHORT, EXT_LONG: begin
				remain_q = {remain_q[55:0], b};
				hdr_cnt = hdr_cnt + 3'd1;
				if ((phase_q == EXT_SHORT && hdr_cnt == EXT16_BYTES) ||
						(phase_q == EXT_LONG && hdr_cnt == 3'd0)) begin
					finish_length();
				end
			end
			KEY_BYTES: begin
				key_q[hdr_cnt[1:0]] = b;
				if (hdr_cnt == MASK_LAST_IDX) begin
					finish_header();
				end else begin
					hdr_cnt = hdr_cnt + 3'd1;
				end
			end
			PAYLOAD: begin
				d = b;
				if (masked_q) begin
					d = d ^ key_q[key_pos];
					key_pos = key_pos + 2'd1;
				end
				remain_q = remain_q - 64'd1;
				push_result(d, 1'b0, remain_q == 64'd0);
				if (remain_q == 64'd0) begin
					phase_q = AWAIT_FIRST;
				end
			end
			default: begin
				fin_q = b[7];
				op_q = b[3:0];
				hdr_cnt = 3'd0;
				phase_q = AWAIT_LEN;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q = AWAIT_FIRST;
			hdr_cnt = 3'd0;
			fin_q = 1'b0;
			op_q = 4'd0;
			masked_q = 1'b0;
			remain_q = 64'd0;
			for (int i = 0; i < 4; i++) key_q[i] = 8'd0;
			key_pos = 2'd0;
			expected_results.delete();
			end_checked = 1'b0;
			fail_count = 0;
		end else begin
			if (raw.valid && raw.ready) begin
				parse_byte(raw.in_byte);
			end
			if (frame.valid && frame.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, payload_byte",
						64'(frame.payload_byte), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (frame.payload_byte !== want.data)
						report_mismatch("payload_byte", 64'(frame.payload_byte),
							64'(want.data));
					if (frame.frame_opcode !== want.opcode)
						report_mismatch("frame_opcode", 64'(frame.frame_opcode),
							64'(want.opcode));
					if (frame.final_fragment !== want.fin)
						report_mismatch("final_fragment", 64'(frame.final_fragment),
							64'(want.fin));
					if (frame.was_masked !== want.masked)
						report_mismatch("was_masked", 64'(frame.was_masked),
							64'(want.masked));
					if (frame.empty_frame !== want.empty)
						report_mismatch("empty_frame", 64'(frame.empty_frame),
							64'(want.empty));
					if (frame.last !== want.last)
						report_mismatch("last", 64'(frame.last), 64'(want.last));
				end
			end
			if (end_of_run && !end_checked) begin
				end_checked = 1'b1;
				if (expected_results.size() != 0)
					report_mismatch("results never delivered", 64'd0,
						64'(expected_results.size()));
			end
		end
		pending = unsigned'(expected_results.size());
	end

endmodule

// File: test/websocket_frame_deframer_unmask_top_test.sv
`timescale 1ns / 100ps
module websocket_frame_deframer_unmask_top_test;
	import wsd_pkg::*;

	// websocket opcodes used to build frames
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;
	localparam logic [3:0] OP_RSVD_F = 4'hF;
	localparam logic [3:0] COMMON_OPS [0:5] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE,
		OP_PING, OP_PONG};

	// how the payload length is carried in the header
	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	// stop generating random traffic once this many link bytes went in
	localparam int unsigned LINK_BYTE_TARGET = 1700;

	logic        clk;
	logic        arst_n;
	logic        end_of_run;
	logic        at_frame_start;
	int unsigned pending;
	int unsigned fail_count;

	// bytes of the frame being built, sent front first
	logic [7:0]  link_q[$];
	int unsigned link_bytes_sent;
	int          burst_left;

	wsd_raw_if   raw();
	wsd_frame_if frame();

	websocket_frame_deframer_unmask_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.raw   (raw),
		.frame (frame)
	);

	// predicts results from accepted link bytes and compares what comes out
	websocket_frame_deframer_unmask_checker i_frame_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.raw           (raw),
		.frame         (frame),
		.end_of_run    (end_of_run),
		.at_frame_start(at_frame_start),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// header bytes: first byte, length code, optional extended length, optional key
	function automatic void add_header(input logic fin, input logic [2:0] rsv,
			input logic [3:0] op, input logic masked, input logic [63:0] len,
			input len_form_t form, input logic [31:0] key);
		link_q.push_back({fin, rsv, op});
		case (form)
			LEN_EXT16: begin
				link_q.push_back({masked, LEN_CODE_EXT16});
				link_q.push_back(len[15:8]);
				link_q.push_back(len[7:0]);
			end
			LEN_EXT64: begin
				link_q.push_back({masked, LEN_CODE_EXT64});
				for (int i = 7; i >= 0; i--) link_q.push_back(len[8*i +: 8]);
			end
			default: link_q.push_back({masked, len[6:0]});
		endcase
		if (masked) begin
			for (int i = 3; i >= 0; i--) link_q.push_back(key[8*i +: 8]);
		end
	endfunction

	// one request on raw, with bursts of random length and random gaps between them
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				raw.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
				: $urandom_range(1, 16);
		end
		raw.valid   <= 1'b1;
		raw.in_byte <= b;
		do @(posedge clk); while (!raw.ready);
		burst_left--;
		link_bytes_sent++;
	endtask

	// send the first count bytes of the built frame and drop the rest
	task automatic send_queued(input int count);
		for (int i = 0; i < count; i++) send_byte(link_q[i]);
		link_q.delete();
	endtask

	// after a cut frame or noise: feed zero bytes one at a time until the parser
	// is back at a frame boundary; valid drops after each so the status has settled
	task automatic resync();
		raw.valid <= 1'b0;
		@(posedge clk);
		while (!at_frame_start) begin
			raw.valid   <= 1'b1;
			raw.in_byte <= 8'h00;
			do @(posedge clk); while (!raw.ready);
			link_bytes_sent++;
			raw.valid <= 1'b0;
			@(posedge clk);
		end
		burst_left = 0;
	endtask

	// well-formed frame with random content; cut short when asked
	task automatic random_frame(input bit cut_short);
		logic [3:0]  op;
		logic [63:0] len;
		logic [31:0] key;
		logic        masked;
		len_form_t   form;
		int          pick;
		op = ($urandom_range(0, 9) < 7) ? COMMON_OPS[$urandom_range(0, 5)]
			: 4'($urandom_range(0, 15));
		masked = 1'($urandom_range(0, 1));
		// mostly short payloads; a few at the top of the 7-bit range and
		// non-minimal extended lengths, zero among them
		pick = $urandom_range(0, 99);
		form = LEN_SHORT;
		if (pick < 45) begin
			len = 64'($urandom_range(0, 12));
		end else if (pick < 55) begin
			len = 64'($urandom_range(0, 125));
		end else if (pick < 60) begin
			len = 64'd125;
		end else if (pick < 63) begin
			len = 64'd0;
		end else if (pick < 78) begin
			form = LEN_EXT16;
			len = 64'($urandom_range(0, 40));
		end else if (pick < 81) begin
			form = LEN_EXT16;
			len = 64'($urandom_range(256, 300));
		end else begin
			form = LEN_EXT64;
			len = 64'($urandom_range(0, 30));
		end
		pick = $urandom_range(0, 9);
		key = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		add_header(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op, masked, len,
			form, key);
		repeat (int'(len)) link_q.push_back(8'($urandom_range(0, 255)));
		if (cut_short) begin
			send_queued($urandom_range(1, link_q.size() - 1));
			resync();
		end else begin
			send_queued(link_q.size());
		end
	endtask

	// random bytes at a frame boundary; length codes stay below the extended
	// codes so that the parser always comes back within a bounded run of zeros
	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			link_q.push_back({1'($urandom_range(0, 1)), 7'($urandom_range(0, 125))});
		end
		send_queued(link_q.size());
		resync();
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int          pick;
		int unsigned waited;
		raw.valid       = 1'b0;
		raw.in_byte     = 8'h00;
		arst_n          = 1'b0;
		end_of_run      = 1'b0;
		link_bytes_sent = 0;
		burst_left      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty frame with every reserved bit and the top opcode
		add_header(1'b1, 3'b111, OP_RSVD_F, 1'b0, 64'd0, LEN_SHORT, 32'h0);
		// close frame, masked, its status code carried as plain payload
		add_header(1'b1, 3'b000, OP_CLOSE, 1'b1, 64'd2, LEN_SHORT, 32'hFF00_A55A);
		link_q.push_back(8'h03);
		link_q.push_back(8'hE8);
		// 16-bit extended length of one, non-minimal
		add_header(1'b0, 3'b000, OP_BINARY, 1'b0, 64'd1, LEN_EXT16, 32'h0);
		link_q.push_back(8'hFF);
		// 64-bit extended length of zero gives an empty result
		add_header(1'b0, 3'b000, OP_TEXT, 1'b0, 64'd0, LEN_EXT64, 32'h0);
		send_queued(link_q.size());

		// random part: mostly whole frames, some cut short, some noise
		while (link_bytes_sent < LINK_BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				random_frame(1'b0);
			end else if (pick < 90) begin
				random_frame(1'b1);
			end else begin
				send_noise();
			end
		end

		// 64-bit length with its top bit set is a plain count: the frame never ends here
		add_header(1'b1, 3'b000, OP_BINARY, 1'b1, 64'h8000_0000_0000_0005, LEN_EXT64,
			$urandom);
		repeat (40) link_q.push_back(8'($urandom_range(0, 255)));
		send_queued(link_q.size());
		raw.valid <= 1'b0;

		// drain: wait for every predicted result, bounded, then the block's latency
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		end_of_run <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// frame side: ready stalls on segments of random style, plus one long
	// hold-off so the output register stays full and raw backs up
	initial begin : receiver
		int          seg;
		int          mode;
		int unsigned run_cycles;
		bit          hold_done;
		frame.ready = 1'b0;
		run_cycles  = 0;
		hold_done   = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && run_cycles >= 1500) begin
				frame.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			seg  = $urandom_range(1, 40);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				case (mode)
					0: frame.ready <= 1'b1;
					1: frame.ready <= 1'($urandom_range(0, 1));
					2: frame.ready <= ($urandom_range(0, 7) != 0);
					default: frame.ready <= 1'b0;
				endcase
				@(posedge clk);
				run_cycles++;
			end
		end
	end

	// hard stop in case a handshake hangs
	initial begin : watchdog
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: websocket_frame_deframer_unmask_top.f
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_raw_if.sv
sv/wsd_frame_if.sv
sv/wsd_parser.sv
sv/wsd_out_stage.sv
sv/websocket_frame_deframer_unmask_top.sv
test/websocket_frame_deframer_unmask_checker.sv
test/websocket_frame_deframer_unmask_top_test.sv
